FILE: sv/wor_pkg.sv
// wor_pkg: types and constants shared by the outlier rejection filter.
// No dependencies.
package wor_pkg;

  localparam int unsigned MAX_WINDOW = 64;

  localparam int unsigned TEMP_W = 16;
  localparam int unsigned VEL_W  = 24;
  localparam int unsigned CUR_W  = 16;
  localparam int unsigned VD_W   = 32;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [IDX_W-1:0] REG_GEAR_RATIO    = 2'd1;
  localparam logic [IDX_W-1:0] REG_DEAD_BAND     = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VEL,
    ST_WRITE,
    ST_RD,
    ST_ACC,
    ST_DMUL,
    ST_DCALC,
    ST_AMUL,
    ST_CMP,
    ST_PREV,
    ST_PREVW,
    ST_FIX,
    ST_OUT
  } wor_state_t;

endpackage

FILE: sv/wor_ram.sv
// wor_ram: generic single port write, single port registered read RAM.
// No dependencies.
module wor_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/wor_mul.sv
// wor_mul: shared registered 33x33 signed multiplier, one product per cycle.
// Depends on nothing.
module wor_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p_r
);
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
endmodule

FILE: sv/windowed_outlier_rejection_filter.sv
// windowed_outlier_rejection_filter: top level, sequencer and datapath.
// Depends on wor_pkg, wor_ram, wor_mul.
//
//  channel | ports                      | handshake
//  --------+----------------------------+----------------------------
//  in      | in_req_type .. in_current  | in_valid / in_stall
//  out     | out_window_full .. vdiff   | out_valid / out_stall
//  cfg     | cfg_we, cfg_index, cfg_data| write enable, no wait
//
// A clear item goes straight to the output. A sample item is written to the
// window RAM; once the window is full (L = window length) a pass follows over
// its L entries through the single RAM read port, with one square per entry
// through the shared multiplier.
// Reset clears fill count, write position and handshake state; the window
// RAM is never cleared, only entries written since the last clear are read.
// A stalled result holds in the output register; in_stall is high whenever
// an item is in work or a result waits.
module windowed_outlier_rejection_filter
  import wor_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_req_type,
  input  logic signed [15:0]      in_motor_temperature,
  input  logic signed [23:0]      in_motor_velocity,
  input  logic signed [23:0]      in_joint_velocity,
  input  logic signed [15:0]      in_motor_current,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_window_full,
  output logic signed [15:0]      out_adjusted_temperature,
  output logic                    out_outlier_seen,
  output logic signed [1:0]       out_current_sign,
  output logic signed [31:0]      out_velocity_difference,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);
  localparam int unsigned AW = $clog2(MAX_WINDOW);
  localparam int unsigned CW = $clog2(MAX_WINDOW + 1);

  // configuration
  logic [6:0]  win_len_r;
  logic [15:0] gear_r;
  logic [14:0] dead_band_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r   <= 7'd10;
      gear_r      <= 16'd25600;
      dead_band_r <= 15'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: win_len_r   <= cfg_data[6:0];
        REG_GEAR_RATIO:    gear_r      <= cfg_data;
        REG_DEAD_BAND:     dead_band_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // effective length, clamped to [2, MAX_WINDOW]
  logic [CW-1:0] len;
  always_comb begin
    if ({25'd0, win_len_r} < 32'd2) len = CW'(2);
    else if ({25'd0, win_len_r} > 32'(MAX_WINDOW)) len = CW'(MAX_WINDOW);
    else len = CW'(win_len_r);
  end

  wor_state_t state_r, state_nxt;

  logic [CW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] wpos_r, wpos_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] kacc_r, kacc_nxt;

  logic signed [15:0] temp_r, temp_nxt;
  logic signed [23:0] mvel_r, mvel_nxt;
  logic signed [23:0] jvel_r, jvel_nxt;
  logic signed [15:0] cur_r, cur_nxt;

  logic signed [22:0] s_r, s_nxt;     // sum of up to 64 Q8.8 values
  logic [37:0]        q_r, q_nxt;     // sum of squares
  logic [45:0]        d_r, d_nxt;     // L*Q - S*S
  logic [27:0]        a_r, a_nxt;     // 5*|L*x - S| - 384*L, when positive
  logic               apos_r, apos_nxt;
  logic               dsub_r, dsub_nxt;

  logic               ov_r, ov_nxt;
  logic               o_full_r, o_full_nxt;
  logic signed [15:0] o_adj_r, o_adj_nxt;
  logic               o_outl_r, o_outl_nxt;
  logic signed [1:0]  o_sign_r, o_sign_nxt;
  logic signed [31:0] o_vd_r, o_vd_nxt;

  // RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  wor_ram #(.WIDTH(16), .DEPTH(MAX_WINDOW)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  wor_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(mul_p));

  // address of the entry k back from the newest (newest is slot_r)
  logic [AW-1:0] back_addr;
  assign back_addr = slot_r - k_r[AW-1:0];

  assign in_stall  = (state_r != ST_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_window_full          = o_full_r;
  assign out_adjusted_temperature = o_adj_r;
  assign out_outlier_seen         = o_outl_r;
  assign out_current_sign         = o_sign_r;
  assign out_velocity_difference  = o_vd_r;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = in_req_type ? ST_OUT : ST_VEL;
      ST_VEL:   state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = (fill_nxt >= len) ? ST_RD : ST_OUT;
      ST_RD:    state_nxt = ST_ACC;
      ST_ACC:   state_nxt = (kacc_r == len - CW'(1)) ? ST_DMUL : ST_ACC;
      ST_DMUL:  state_nxt = ST_DCALC;
      ST_DCALC: state_nxt = ST_AMUL;
      ST_AMUL:  state_nxt = ST_CMP;
      ST_CMP:   state_nxt = ST_PREV;
      ST_PREV:  state_nxt = ST_PREVW;
      ST_PREVW: state_nxt = ST_FIX;
      ST_FIX:   state_nxt = ST_OUT;
      ST_OUT:   if (!ov_r) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  logic signed [64:0] vd_full;
  logic signed [31:0] lx_minus_s;
  logic [31:0]        dev_abs;
  logic signed [33:0] a_tmp;

  always_comb begin
    fill_nxt = fill_r; wpos_nxt = wpos_r; slot_nxt = slot_r;
    k_nxt = k_r; kacc_nxt = kacc_r;
    temp_nxt = temp_r; mvel_nxt = mvel_r; jvel_nxt = jvel_r; cur_nxt = cur_r;
    s_nxt = s_r; q_nxt = q_r; d_nxt = d_r; a_nxt = a_r; apos_nxt = apos_r;
    dsub_nxt = dsub_r;
    ov_nxt = ov_r;
    o_full_nxt = o_full_r; o_adj_nxt = o_adj_r; o_outl_nxt = o_outl_r;
    o_sign_nxt = o_sign_r; o_vd_nxt = o_vd_r;
    ram_we = 1'b0; ram_waddr = slot_r; ram_wdata = temp_r; ram_raddr = back_addr;
    mul_a = '0; mul_b = '0;
    vd_full = '0; lx_minus_s = '0; dev_abs = '0; a_tmp = '0;

    if (ov_r && !out_stall) ov_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          temp_nxt = in_motor_temperature; mvel_nxt = in_motor_velocity;
          jvel_nxt = in_joint_velocity; cur_nxt = in_motor_current;
          o_full_nxt = 1'b0; o_adj_nxt = '0; o_outl_nxt = 1'b0;
          o_sign_nxt = '0; o_vd_nxt = '0;
          if (in_req_type) begin
            fill_nxt = '0; wpos_nxt = '0;
          end
        end
      end
      ST_VEL: begin
        mul_a = 33'(signed'({1'b0, gear_r}));
        mul_b = 33'(jvel_r);
        if (cur_r > signed'({2'b00, dead_band_r})) o_sign_nxt = 2'sd1;
        else if (cur_r < -signed'({2'b00, dead_band_r})) o_sign_nxt = -2'sd1;
      end
      ST_WRITE: begin
        vd_full = 65'(mul_p) - (65'(mvel_r) <<< 8);
        vd_full = vd_full >>> 8;
        if (vd_full > 65'sd2147483647) o_vd_nxt = 32'sh7fffffff;
        else if (vd_full < -65'sd2147483648) o_vd_nxt = 32'sh80000000;
        else o_vd_nxt = vd_full[31:0];
        ram_we = 1'b1; ram_waddr = wpos_r; ram_wdata = temp_r;
        slot_nxt = wpos_r;
        wpos_nxt = wpos_r + AW'(1);
        fill_nxt = (fill_r + CW'(1) > len) ? len : fill_r + CW'(1);
        k_nxt = '0; kacc_nxt = '0; s_nxt = '0; q_nxt = '0;
      end
      ST_RD: begin
        // issue read of the newest entry; data lands in the first ACC cycle
        k_nxt = k_r + CW'(1);
      end
      ST_ACC: begin
        // ram_rdata holds entry kacc, the read of entry k goes out meanwhile;
        // the square of entry kacc is ready in the next cycle
        mul_a = 33'(signed'(ram_rdata));
        mul_b = 33'(signed'(ram_rdata));
        s_nxt = s_r + 23'(signed'(ram_rdata));
        if (kacc_r != '0) q_nxt = q_r + mul_p[37:0];
        kacc_nxt = kacc_r + CW'(1);
        k_nxt = k_r + CW'(1);
      end
      ST_DMUL: begin
        q_nxt = q_r + mul_p[37:0];
        mul_a = 33'(s_r);
        mul_b = 33'(s_r);
      end
      ST_DCALC: begin
        // d = L*Q - S*S ; L*Q by shift-free small multiply (L <= 64)
        d_nxt = 46'(q_r) * 46'(len) - 46'(mul_p[45:0]);
        mul_a = 33'(signed'({1'b0, len}));
        mul_b = 33'(temp_r);
      end
      ST_AMUL: begin
        lx_minus_s = 32'(mul_p) - 32'(s_r);
        dev_abs = lx_minus_s[31] ? -lx_minus_s : lx_minus_s;
        a_tmp = 34'(dev_abs) * 34'sd5 - 34'(384) * 34'(len);
        apos_nxt = (a_tmp > 0);
        a_nxt = a_tmp[27:0];
        dsub_nxt = 1'b0;
      end
      ST_CMP: begin
        mul_a = 33'(a_r);
        mul_b = 33'(a_r);
      end
      ST_PREV: begin
        dsub_nxt = apos_r && ({2'b00, mul_p[63:0]} > 66'(d_r) * 66'd225);
        k_nxt = CW'(1);
      end
      ST_PREVW: begin
        ram_raddr = slot_r - AW'(1);
      end
      ST_FIX: begin
        o_full_nxt = 1'b1;
        if (dsub_r) begin
          o_adj_nxt = ram_rdata; o_outl_nxt = 1'b1;
          ram_we = 1'b1; ram_waddr = slot_r; ram_wdata = ram_rdata;
        end else begin
          o_adj_nxt = temp_r;
        end
      end
      ST_OUT: begin
        if (!ov_r) ov_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      wpos_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      wpos_r  <= wpos_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt; k_r <= k_nxt; kacc_r <= kacc_nxt;
    temp_r <= temp_nxt; mvel_r <= mvel_nxt; jvel_r <= jvel_nxt; cur_r <= cur_nxt;
    s_r <= s_nxt; q_r <= q_nxt; d_r <= d_nxt; a_r <= a_nxt; apos_r <= apos_nxt;
    dsub_r <= dsub_nxt;
    o_full_r <= o_full_nxt; o_adj_r <= o_adj_nxt; o_outl_r <= o_outl_nxt;
    o_sign_r <= o_sign_nxt; o_vd_r <= o_vd_nxt;
  end
endmodule
